### src/rmf_pkg.sv
`timescale 1ns / 1ps

package rmf_pkg;

  localparam int MaxWidth    = 2048;
  localparam int ChannelBits = 8;
  localparam int ColW        = $clog2(MaxWidth);
  localparam int CfgWidthW   = 12;
  localparam int CfgHeightW  = 16;
  localparam int CfgDataW    = 16;
  localparam int RowW        = 16;
  localparam int MinDim      = 3;

  typedef logic [ChannelBits-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_in_t;

  typedef struct packed {
    chan_t            out_red;
    chan_t            out_green;
    chan_t            out_blue;
    logic [RowW-1:0]  out_row;
    logic [ColW-1:0]  out_col;
    logic             frame_end;
  } pixel_out_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            frame_end;
  } meta_t;

  // nine samples of one channel, column-major: column k holds entries 3k..3k+2
  typedef chan_t [8:0] win_t;

  typedef struct packed {
    chan_t hi;
    chan_t md;
    chan_t lo;
  } trio_t;

  typedef enum logic {
    CfgImageWidth  = 1'b0,
    CfgImageHeight = 1'b1
  } cfg_idx_e;

  function automatic trio_t sort3(chan_t a, chan_t b, chan_t c);
    chan_t l0;
    chan_t h0;
    chan_t m1;
    trio_t t;
    l0   = (a < b) ? a : b;
    h0   = (a < b) ? b : a;
    t.hi = (h0 > c) ? h0 : c;
    m1   = (h0 > c) ? c : h0;
    t.lo = (l0 < m1) ? l0 : m1;
    t.md = (l0 < m1) ? m1 : l0;
    return t;
  endfunction

endpackage

### src/rmf_ram.sv
`timescale 1ns / 1ps

module rmf_ram #(
  parameter int Width = 48,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/rmf_median.sv
`timescale 1ns / 1ps

// Median of nine: sort each column, then take the max of the lows, the median
// of the middles and the min of the highs; the median of those three is it.
module rmf_median (
  input  logic           clk_i,
  input  logic           en_i,
  input  rmf_pkg::win_t  win_i,
  output rmf_pkg::chan_t med_o
);

  rmf_pkg::trio_t col_d [3];
  rmf_pkg::trio_t col_q [3];
  rmf_pkg::trio_t lmh_d;
  rmf_pkg::trio_t lmh_q;
  rmf_pkg::trio_t lo_srt;
  rmf_pkg::trio_t md_srt;
  rmf_pkg::trio_t hi_srt;
  rmf_pkg::trio_t fin;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      col_d[k] = rmf_pkg::sort3(win_i[3*k], win_i[3*k+1], win_i[3*k+2]);
    end
    lo_srt   = rmf_pkg::sort3(col_q[0].lo, col_q[1].lo, col_q[2].lo);
    md_srt   = rmf_pkg::sort3(col_q[0].md, col_q[1].md, col_q[2].md);
    hi_srt   = rmf_pkg::sort3(col_q[0].hi, col_q[1].hi, col_q[2].hi);
    lmh_d.lo = lo_srt.hi;
    lmh_d.md = md_srt.md;
    lmh_d.hi = hi_srt.lo;
    fin      = rmf_pkg::sort3(lmh_q.lo, lmh_q.md, lmh_q.hi);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      col_q <= col_d;
      lmh_q <= lmh_d;
    end
  end

  assign med_o = fin.md;

endmodule

### src/rgb_median_3x3_filter.sv
`timescale 1ns / 1ps

// After its item is accepted, a result passes through the line memory read,
// the column sort, min/med/max and the output register, in that order.
// Throughput: one item per cycle; a stalled result freezes the whole pipeline.
// Reset: counters to row 0 column 0, size to 640 x 480, pipeline empty.
// The line memory is not cleared; rows are written before they are read.
module rgb_median_3x3_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  rmf_pkg::pixel_in_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rmf_pkg::pixel_out_t               out_data_o,
  input  logic                              cfg_we_i,
  input  rmf_pkg::cfg_idx_e                 cfg_idx_i,
  input  logic [rmf_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  localparam int PxW = $bits(rmf_pkg::pixel_in_t);

  logic [rmf_pkg::CfgWidthW-1:0]  cfg_width_q;
  logic [rmf_pkg::CfgHeightW-1:0] cfg_height_q;
  logic [rmf_pkg::CfgWidthW-1:0]  w_eff;
  logic [rmf_pkg::CfgHeightW-1:0] h_eff;

  logic [rmf_pkg::ColW-1:0] col_q, col_d;
  logic [rmf_pkg::RowW-1:0] row_q, row_d;
  logic [rmf_pkg::CfgWidthW-1:0] col_inc;
  logic [rmf_pkg::RowW:0]        row_inc;
  logic                          emit;
  rmf_pkg::meta_t                meta_d;

  logic en;
  logic accept;

  logic                     s1_valid_q;
  logic                     s1_emit_q;
  rmf_pkg::pixel_in_t       s1_px_q;
  logic [rmf_pkg::ColW-1:0] s1_col_q;
  rmf_pkg::meta_t           s1_meta_q;

  logic           s2_valid_q, s3_valid_q, out_valid_q;
  rmf_pkg::meta_t s2_meta_q, s3_meta_q;
  rmf_pkg::pixel_out_t out_q;

  logic [2*PxW-1:0]   ram_rdata;
  rmf_pkg::pixel_in_t top_px, mid_px;

  rmf_pkg::pixel_in_t win_q [6];
  rmf_pkg::pixel_in_t win_px [9];
  rmf_pkg::win_t      win_r, win_g, win_b;
  rmf_pkg::chan_t     med_r, med_g, med_b;

  assign en         = !out_valid_q || !out_stall_i;
  assign accept     = in_valid_i && en;
  assign in_stall_o = !en;

  // clamp the width to at least 3 and to what the line memory holds, the height to at least 3
  always_comb begin
    w_eff = cfg_width_q;
    if (cfg_width_q < rmf_pkg::CfgWidthW'(rmf_pkg::MinDim)) begin
      w_eff = rmf_pkg::CfgWidthW'(rmf_pkg::MinDim);
    end else if (cfg_width_q > rmf_pkg::CfgWidthW'(rmf_pkg::MaxWidth)) begin
      w_eff = rmf_pkg::CfgWidthW'(rmf_pkg::MaxWidth);
    end
    h_eff = cfg_height_q;
    if (cfg_height_q < rmf_pkg::CfgHeightW'(rmf_pkg::MinDim)) begin
      h_eff = rmf_pkg::CfgHeightW'(rmf_pkg::MinDim);
    end
  end

  always_comb begin
    col_inc = {1'b0, col_q} + rmf_pkg::CfgWidthW'(1);
    row_inc = {1'b0, row_q} + (rmf_pkg::RowW + 1)'(1);
    row_d   = row_q;
    col_d   = col_inc[rmf_pkg::ColW-1:0];
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[rmf_pkg::RowW-1:0];
    end
    emit             = (row_q >= rmf_pkg::RowW'(2)) && (col_q >= rmf_pkg::ColW'(2));
    meta_d.row       = row_q - rmf_pkg::RowW'(1);
    meta_d.col       = col_q - rmf_pkg::ColW'(1);
    meta_d.frame_end = (row_q == h_eff - rmf_pkg::CfgHeightW'(1)) &&
                       ({1'b0, col_q} == w_eff - rmf_pkg::CfgWidthW'(1));
  end

  // configuration and raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= rmf_pkg::CfgWidthW'(640);
      cfg_height_q <= rmf_pkg::CfgHeightW'(480);
      col_q        <= '0;
      row_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rmf_pkg::CfgImageWidth:  cfg_width_q  <= cfg_wdata_i[rmf_pkg::CfgWidthW-1:0];
        rmf_pkg::CfgImageHeight: cfg_height_q <= cfg_wdata_i[rmf_pkg::CfgHeightW-1:0];
        default: ;
      endcase
      // restart the frame
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line memory: upper half is row r-2, lower half is row r-1
  rmf_ram #(
    .Width (2 * PxW),
    .Depth (rmf_pkg::MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q && en),
    .waddr_i (s1_col_q),
    .wdata_i ({mid_px, s1_px_q}),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  assign top_px = rmf_pkg::pixel_in_t'(ram_rdata[2*PxW-1:PxW]);
  assign mid_px = rmf_pkg::pixel_in_t'(ram_rdata[PxW-1:0]);

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      win_px[k] = win_q[k];
    end
    win_px[6] = top_px;
    win_px[7] = mid_px;
    win_px[8] = s1_px_q;
    for (int k = 0; k < 9; k++) begin
      win_r[k] = win_px[k].red;
      win_g[k] = win_px[k].green;
      win_b[k] = win_px[k].blue;
    end
  end

  rmf_median u_med_r (.clk_i(clk_i), .en_i(en), .win_i(win_r), .med_o(med_r));
  rmf_median u_med_g (.clk_i(clk_i), .en_i(en), .win_i(win_g), .med_o(med_g));
  rmf_median u_med_b (.clk_i(clk_i), .en_i(en), .win_i(win_b), .med_o(med_b));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_emit_q   <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= accept;
      s1_emit_q   <= accept && emit;
      s2_valid_q  <= s1_valid_q && s1_emit_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= in_data_i;
      s1_col_q  <= col_q;
      s1_meta_q <= meta_d;
    end
    if (en) begin
      // shift the window one column as the item leaves the first stage
      if (s1_valid_q) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top_px;
        win_q[4] <= mid_px;
        win_q[5] <= s1_px_q;
      end
      s2_meta_q       <= s1_meta_q;
      s3_meta_q       <= s2_meta_q;
      out_q.out_red   <= med_r;
      out_q.out_green <= med_g;
      out_q.out_blue  <= med_b;
      out_q.out_row   <= s3_meta_q.row;
      out_q.out_col   <= s3_meta_q.col;
      out_q.frame_end <= s3_meta_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // a new read never hits the entry the previous item is writing back
  a_rw_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s1_valid_q |-> col_q != s1_col_q)
    else $error("line memory read and write collide");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, col_q} < w_eff)
    else $error("column counter beyond row width");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q < h_eff)
    else $error("row counter beyond frame height");

  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.out_row != '0 && out_q.out_col != '0)
    else $error("result item on a border pixel");
`endif

endmodule

### bench/tb_rgb_median_3x3_filter.sv
`timescale 1ns / 1ps

module tb_rgb_median_3x3_filter;

  typedef rmf_pkg::chan_t nine_t [9];
  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  logic                         clk_i;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  rmf_pkg::pixel_in_t           in_data_i   = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  rmf_pkg::pixel_out_t          out_data_o;
  logic                         cfg_we_i    = 1'b0;
  rmf_pkg::cfg_idx_e            cfg_idx_i   = rmf_pkg::CfgImageWidth;
  logic [rmf_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  // predictor state: two previous rows, two previous window columns, raster position
  rmf_pkg::pixel_in_t             line_mem [2*rmf_pkg::MaxWidth];
  rmf_pkg::pixel_in_t             win_cols [6];
  int unsigned                    row_cnt    = 0;
  int unsigned                    col_cnt    = 0;
  logic [rmf_pkg::CfgWidthW-1:0]  width_reg  = 12'd640;
  logic [rmf_pkg::CfgHeightW-1:0] height_reg = 16'd480;

  rmf_pkg::pixel_in_t  pixel_q [$];
  rmf_pkg::pixel_out_t median_q [$];
  int unsigned sent_cnt   = 0;
  int unsigned result_cnt = 0;
  int unsigned write_cnt  = 0;
  int unsigned fail_cnt   = 0;

  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  stall_mode_e stall_mode = StallNone;
  int unsigned stall_hold = 0;
  int unsigned stall_tick = 0;

  rgb_median_3x3_filter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #15ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned eff_cols();
    if (width_reg < rmf_pkg::MinDim) return rmf_pkg::MinDim;
    if (width_reg > rmf_pkg::MaxWidth) return rmf_pkg::MaxWidth;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_rows();
    return (height_reg < rmf_pkg::MinDim) ? rmf_pkg::MinDim : 32'(height_reg);
  endfunction

  function automatic rmf_pkg::chan_t median_of_nine(nine_t v);
    rmf_pkg::chan_t s [9];
    rmf_pkg::chan_t x;
    int             j;
    for (int i = 0; i < 9; i++) begin
      x = v[i];
      j = i;
      while (j > 0 && s[j-1] > x) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = x;
    end
    return s[4];
  endfunction

  function automatic rmf_pkg::pixel_in_t rand_pixel(int mode);
    rmf_pkg::pixel_in_t p;
    case (mode)
      0: p = rmf_pkg::pixel_in_t'(24'($urandom));
      1: begin
        p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: begin
        // narrow spread: lots of ties in the sort
        p.red   = 8'h70 + rmf_pkg::chan_t'($urandom_range(0, 3));
        p.green = 8'h70 + rmf_pkg::chan_t'($urandom_range(0, 3));
        p.blue  = 8'h70 + rmf_pkg::chan_t'($urandom_range(0, 3));
      end
    endcase
    return p;
  endfunction

  // advance the filter by one pixel and queue the median it yields, if interior
  task automatic filter_pixel(rmf_pkg::pixel_in_t px);
    int unsigned         w;
    int unsigned         h;
    int unsigned         c;
    int unsigned         r;
    rmf_pkg::pixel_in_t  top;
    rmf_pkg::pixel_in_t  mid;
    rmf_pkg::pixel_in_t  win [9];
    nine_t               reds;
    nine_t               greens;
    nine_t               blues;
    rmf_pkg::pixel_out_t res;
    w = eff_cols();
    h = eff_rows();
    c = col_cnt;
    r = row_cnt;
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    top = line_mem[rmf_pkg::MaxWidth + c];
    mid = line_mem[c];
    for (int k = 0; k < 6; k++) win[k] = win_cols[k];
    win[6] = top;
    win[7] = mid;
    win[8] = px;
    if (r >= 2 && c >= 2) begin
      for (int k = 0; k < 9; k++) begin
        reds[k]   = win[k].red;
        greens[k] = win[k].green;
        blues[k]  = win[k].blue;
      end
      res.out_red   = median_of_nine(reds);
      res.out_green = median_of_nine(greens);
      res.out_blue  = median_of_nine(blues);
      res.out_row   = rmf_pkg::RowW'(r - 1);
      res.out_col   = rmf_pkg::ColW'(c - 1);
      res.frame_end = (r == h - 1) && (c == w - 1);
      median_q = {median_q, res};
    end
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = top;
    win_cols[4] = mid;
    win_cols[5] = px;
    line_mem[rmf_pkg::MaxWidth + c] = mid;
    line_mem[c] = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endtask

  // write one register; the frame restarts at row 0, column 0
  task automatic write_reg(rmf_pkg::cfg_idx_e idx, logic [rmf_pkg::CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rmf_pkg::CfgImageWidth) width_reg = value[rmf_pkg::CfgWidthW-1:0];
    else height_reg = value[rmf_pkg::CfgHeightW-1:0];
    row_cnt = 0;
    col_cnt = 0;
    write_cnt++;
  endtask

  task automatic push_pixels(int unsigned n, int mode);
    for (int unsigned i = 0; i < n; i++) pixel_q = {pixel_q, rand_pixel(mode)};
  endtask

  // border pixels give no result, so let the pipeline flush on unstalled cycles
  task automatic wait_idle();
    int quiet;
    quiet = 0;
    while (quiet < 8) begin
      @(posedge clk_i);
      if (pixel_q.size() != 0 || in_valid_i || median_q.size() != 0) quiet = 0;
      else if (!out_stall_i) quiet++;
    end
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk_i) begin : drive_proc
    logic               nxt_valid;
    rmf_pkg::pixel_in_t nxt_data;
    nxt_valid = in_valid_i;
    nxt_data  = in_data_i;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        filter_pixel(in_data_i);
        sent_cnt++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pixel_q.size() != 0) begin
          nxt_valid = 1'b1;
          nxt_data  = pixel_q.pop_front();
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
    end
    in_valid_i <= nxt_valid;
    in_data_i  <= nxt_data;
  end

  // receiver: check each result, stall in changing modes
  always @(posedge clk_i) begin : recv_proc
    rmf_pkg::pixel_out_t want;
    logic                nxt_stall;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (median_q.size() == 0) begin
        $error("result with no pixel pending: row %0d col %0d",
               out_data_o.out_row, out_data_o.out_col);
        fail_cnt++;
      end else begin
        want = median_q.pop_front();
        result_cnt++;
        if (out_data_o.out_red !== want.out_red) begin
          $error("out_red: expected %0d, got %0d", want.out_red, out_data_o.out_red);
          fail_cnt++;
        end
        if (out_data_o.out_green !== want.out_green) begin
          $error("out_green: expected %0d, got %0d", want.out_green, out_data_o.out_green);
          fail_cnt++;
        end
        if (out_data_o.out_blue !== want.out_blue) begin
          $error("out_blue: expected %0d, got %0d", want.out_blue, out_data_o.out_blue);
          fail_cnt++;
        end
        if (out_data_o.out_row !== want.out_row) begin
          $error("out_row: expected %0d, got %0d", want.out_row, out_data_o.out_row);
          fail_cnt++;
        end
        if (out_data_o.out_col !== want.out_col) begin
          $error("out_col: expected %0d, got %0d", want.out_col, out_data_o.out_col);
          fail_cnt++;
        end
        if (out_data_o.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0d, got %0d", want.frame_end, out_data_o.frame_end);
          fail_cnt++;
        end
      end
    end
    if (stall_hold == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_hold = $urandom_range(32, 256);
    end else begin
      stall_hold--;
    end
    stall_tick++;
    case (stall_mode)
      StallNone:  nxt_stall = 1'b0;
      StallLight: nxt_stall = ($urandom_range(0, 9) < 3);
      StallHeavy: nxt_stall = ($urandom_range(0, 9) < 7);
      default:    nxt_stall = (stall_tick % 4 == 0);
    endcase
    out_stall_i <= rst_ni ? nxt_stall : 1'b0;
  end

  initial begin : main_proc
    rmf_pkg::pixel_in_t corner_px [9];
    int unsigned        rand_items;
    int unsigned        n;
    int                 mode;
    corner_px = '{
      '{8'h00, 8'hFF, 8'h01}, '{8'hFF, 8'h00, 8'hFE}, '{8'h00, 8'hFF, 8'h80},
      '{8'hFF, 8'h00, 8'h7F}, '{8'h80, 8'h80, 8'h80}, '{8'h01, 8'hFE, 8'h00},
      '{8'hFE, 8'h01, 8'hFF}, '{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF}
    };
    for (int k = 0; k < 6; k++) win_cols[k] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // undersized frame: width and height both clamp to 3, one interior pixel
    write_reg(rmf_pkg::CfgImageWidth, 16'd2);
    write_reg(rmf_pkg::CfgImageHeight, 16'd0);
    foreach (corner_px[k]) pixel_q = {pixel_q, corner_px[k]};
    wait_idle();
    // stop mid-frame, then restart it with junk above the width field
    push_pixels(5, 1);
    wait_idle();
    write_reg(rmf_pkg::CfgImageWidth, 16'hF003);
    for (int k = 0; k < 9; k++) begin
      pixel_q = {pixel_q, (k == 4) ? 24'h00FF10 : 24'h555555};
    end
    wait_idle();

    // random small frames, some cut short, some running past the frame end
    rand_items = 0;
    while (rand_items < 380) begin
      case ($urandom_range(0, 9))
        0: begin
          write_reg(rmf_pkg::CfgImageWidth, rmf_pkg::CfgDataW'($urandom_range(0, 2)));
        end
        1: begin
          write_reg(rmf_pkg::CfgImageWidth, rmf_pkg::CfgDataW'($urandom_range(13, 40)));
        end
        default: begin
          write_reg(rmf_pkg::CfgImageWidth, rmf_pkg::CfgDataW'($urandom_range(3, 12)));
        end
      endcase
      if ($urandom_range(0, 3) != 0)
        write_reg(rmf_pkg::CfgImageHeight, ($urandom_range(0, 6) == 0) ?
                  rmf_pkg::CfgDataW'($urandom_range(0, 2)) :
                  rmf_pkg::CfgDataW'($urandom_range(3, 8)));
      n = eff_cols() * eff_rows() * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
      // keep one wide frame from taking over the item budget
      if (n > 150) n = 150;
      mode = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      push_pixels(n, mode);
      rand_items += n;
      wait_idle();
    end

    // widest frame: all width bits set, clamps to the line store size; first row only
    write_reg(rmf_pkg::CfgImageWidth, 16'hFFFF);
    write_reg(rmf_pkg::CfgImageHeight, 16'd3);
    push_pixels(40, 0);
    wait_idle();

    // tallest frame: only the first rows, no frame end
    write_reg(rmf_pkg::CfgImageWidth, 16'd3);
    write_reg(rmf_pkg::CfgImageHeight, 16'hFFFF);
    push_pixels(90, 0);
    wait_idle();

    $display("Run covered %0d pixels in, %0d filtered pixels checked, %0d register writes",
             sent_cnt, result_cnt, write_cnt);
    $display("Frame sizes ran from clamped 3x3 to the start of 2048-column and 65535-row frames");
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/rmf_pkg.sv
src/rmf_ram.sv
src/rmf_median.sv
src/rgb_median_3x3_filter.sv
bench/tb_rgb_median_3x3_filter.sv
